FILE: src/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
package bsa_pkg;

    // Field widths
    localparam int SIZE_W   = 16;
    localparam int ADDR_W   = 14;
    localparam int CNT_W    = 11;
    localparam int STATUS_W = 2;

    // Slot geometry: 16-byte slots, 32 map bits held in each cell
    localparam int SLOT_SHIFT  = 4;
    localparam int SEG_BITS    = 32;
    localparam int SEG_W       = $clog2(SEG_BITS);
    localparam int RESET_SLOTS = 1024;

    localparam logic [SIZE_W-1:0] SLOT_BYTES = SIZE_W'(16);

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd3;

    // What a token does as it passes each cell
    typedef enum logic [1:0] {
        MODE_NOP   = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_COUNT = 2'd3
    } mode_t;

    // Control part of the token handed from cell to cell
    typedef struct packed {
        logic  valid;
        mode_t mode;
        logic  found;
        logic  hit;
    } tok_t;

endpackage

FILE: src/bsa_cell.sv
// One cell of the used-map chain: holds 32 used bits and processes the passing token.
module bsa_cell #(
    parameter int IDX_W    = 10,
    parameter int CELL_IDX = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bsa_pkg::CNT_W-1:0] active_n,
    input  bsa_pkg::tok_t             tok_in,
    input  logic [IDX_W-1:0]          idx_in,
    input  logic [bsa_pkg::CNT_W-1:0] cnt_in,
    output bsa_pkg::tok_t             tok_out,
    output logic [IDX_W-1:0]          idx_out,
    output logic [bsa_pkg::CNT_W-1:0] cnt_out
);
    import bsa_pkg::*;

    localparam int BASE  = CELL_IDX * SEG_BITS;
    localparam int CMP_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

    logic [SEG_BITS-1:0] seg_reg, seg_next;
    logic [SEG_BITS-1:0] below_n, avail, lowest;
    logic [SEG_W-1:0]    low_pos, tgt_bit;
    logic                tgt_here, take_here, free_here;
    tok_t                tok_reg, tok_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // Mark the bits of this cell that lie inside the active region
    always_comb
    begin
        for (int j = 0; j < SEG_BITS; j++)
        begin
            below_n[j] = CMP_W'(active_n) > CMP_W'(BASE + j);
        end
    end

    // Isolate the lowest free bit and encode its position
    assign avail  = ~seg_reg & below_n;
    assign lowest = avail & (~avail + SEG_BITS'(1));

    always_comb
    begin
        low_pos = '0;
        for (int j = 0; j < SEG_BITS; j++)
        begin
            if (lowest[j])
            begin
                low_pos = low_pos | SEG_W'(j);
            end
        end
    end

    // Decide what this cell does with the token
    assign tgt_bit   = idx_in[SEG_W-1:0];
    assign tgt_here  = (idx_in >> SEG_W) == IDX_W'(CELL_IDX);
    assign take_here = tok_in.valid && (tok_in.mode == MODE_ALLOC) && !tok_in.found
                       && (|avail);
    assign free_here = tok_in.valid && (tok_in.mode == MODE_FREE) && tgt_here;

    // Update the map bits and build the outgoing token
    always_comb
    begin
        seg_next = seg_reg;
        tok_next = tok_in;
        idx_next = idx_in;
        cnt_next = cnt_in;
        if (take_here)
        begin
            seg_next       = seg_reg | lowest;
            tok_next.found = 1'b1;
            idx_next       = IDX_W'(BASE) + IDX_W'(low_pos);
        end
        if (free_here)
        begin
            seg_next     = seg_reg & ~(SEG_BITS'(1) << tgt_bit);
            tok_next.hit = tok_in.hit | seg_reg[tgt_bit];
        end
        if (tok_in.valid && (tok_in.mode == MODE_COUNT))
        begin
            cnt_next = cnt_in + CNT_W'($countones(avail));
        end
    end

    // Hold map bits and token control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            seg_reg <= seg_next;
            tok_reg <= tok_next;
        end
    end

    // Advance token payload
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;
    assign cnt_out = cnt_reg;

endmodule

FILE: src/bitmap_slot_allocator.sv
// Top level of the bitmap slot allocator: controller, chain of map cells, result register.
//
// Fixed-block allocator over 16-byte slots. The used map sits in a row of cells of
// 32 bits each (ceil(MAX_SLOTS/32) cells). Every item sends one token down the row,
// one cell per cycle; the cell that holds the lowest free slot claims it, and a free
// clears the bit in the cell that owns it. The input channel stalls from acceptance until
// the token has left the last cell and its result has moved to the output register, so
// only one item is in the chain at a time. A write of slot_count starts a recount token
// down the same chain that rebuilds the free count; the input channel stalls until that
// token has left the last cell. The map resets to all free. A finished result waits in
// an output register while the next item is accepted.
module bitmap_slot_allocator #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic [bsa_pkg::SIZE_W-1:0]   request_size,
    input  logic [bsa_pkg::ADDR_W-1:0]   byte_offset,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bsa_pkg::STATUS_W-1:0] status,
    output logic [bsa_pkg::ADDR_W-1:0]   address,
    output logic [bsa_pkg::CNT_W-1:0]    free_slots,
    input  logic                         cfg_wr_en,
    input  logic [bsa_pkg::CNT_W-1:0]    cfg_wr_data
);
    import bsa_pkg::*;

    localparam int NCELLS  = (MAX_SLOTS + SEG_BITS - 1) / SEG_BITS;
    localparam int IDX_W   = SEG_W + $clog2(NCELLS);
    localparam int CNT_TOP = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] MAX_CNT =
        CNT_W'((MAX_SLOTS > CNT_TOP) ? CNT_TOP : MAX_SLOTS);
    localparam logic [CNT_W-1:0] RESET_N =
        CNT_W'((MAX_SLOTS > RESET_SLOTS) ? RESET_SLOTS : MAX_SLOTS);
    localparam int SEL_W = ADDR_W - SLOT_SHIFT;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_WAIT  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic                 recount_req_reg, recount_req_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     free_count_reg, free_count_next;
    logic                 out_valid_reg, out_valid_next;

    tok_t                 head_tok_reg, head_tok_next;
    logic [IDX_W-1:0]     head_idx_reg, head_idx_next;
    logic [STATUS_W-1:0]  pre_status_reg, pre_status_next;

    logic [STATUS_W-1:0]  status_reg, pend_status_reg;
    logic [ADDR_W-1:0]    address_reg, pend_address_reg;
    logic [CNT_W-1:0]     free_slots_reg, pend_free_reg;

    tok_t                 tok [NCELLS+1];
    logic [IDX_W-1:0]     idx [NCELLS+1];
    logic [CNT_W-1:0]     cnt [NCELLS+1];

    logic                 in_take, out_free, free_ok;
    logic [SEL_W-1:0]     slot_sel;
    logic                 load_out_res, load_out_pend, load_pend;
    logic [STATUS_W-1:0]  res_status;
    logic [ADDR_W-1:0]    res_address;
    logic [CNT_W-1:0]     res_free;

    assign in_stall = (state_reg != S_IDLE) || recount_req_reg;
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Check a free offset: aligned and inside the active region
    assign slot_sel = byte_offset[ADDR_W-1:SLOT_SHIFT];
    assign free_ok  = (byte_offset[SLOT_SHIFT-1:0] == '0) && (CNT_W'(slot_sel) < n_reg);

    // Chain of map cells
    assign tok[0] = head_tok_reg;
    assign idx[0] = head_idx_reg;
    assign cnt[0] = '0;

    for (genvar c = 0; c < NCELLS; c++)
    begin : g_cell
        bsa_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (c)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .active_n (n_reg),
            .tok_in   (tok[c]),
            .idx_in   (idx[c]),
            .cnt_in   (cnt[c]),
            .tok_out  (tok[c+1]),
            .idx_out  (idx[c+1]),
            .cnt_out  (cnt[c+1])
        );
    end

    // Form the result from the token leaving the last cell
    always_comb
    begin
        res_status  = pre_status_reg;
        res_address = '0;
        res_free    = free_count_reg;
        case (tok[NCELLS].mode)
            MODE_ALLOC:
            begin
                if (tok[NCELLS].found)
                begin
                    res_status  = ST_OK;
                    res_address = ADDR_W'({idx[NCELLS], SLOT_SHIFT'(0)});
                    if (free_count_reg != '0)
                    begin
                        res_free = free_count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            MODE_FREE:
            begin
                res_status = ST_OK;
                res_free   = free_count_reg + CNT_W'(tok[NCELLS].hit);
            end
            default:
            begin
                res_status = pre_status_reg;
            end
        endcase
    end

    // Sequence launches, results and recounts
    always_comb
    begin
        state_next       = state_reg;
        recount_req_next = recount_req_reg;
        n_next           = n_reg;
        free_count_next  = free_count_reg;
        out_valid_next   = out_valid_reg && out_stall;
        head_tok_next    = '0;
        head_idx_next    = head_idx_reg;
        pre_status_next  = pre_status_reg;
        load_out_res     = 1'b0;
        load_out_pend    = 1'b0;
        load_pend        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    head_tok_next.valid = 1'b1;
                    if (operation == OP_ALLOC)
                    begin
                        head_tok_next.mode = (request_size == SLOT_BYTES) ? MODE_ALLOC
                                                                          : MODE_NOP;
                        pre_status_next = ST_BAD_SIZE;
                    end
                    else
                    begin
                        head_tok_next.mode = free_ok ? MODE_FREE : MODE_NOP;
                        pre_status_next    = ST_BAD_ADDR;
                    end
                    head_idx_next = IDX_W'(slot_sel);
                    state_next    = S_SWEEP;
                end
                else if (recount_req_reg)
                begin
                    head_tok_next.valid = 1'b1;
                    head_tok_next.mode  = MODE_COUNT;
                    recount_req_next    = 1'b0;
                    state_next          = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (tok[NCELLS].valid)
                begin
                    if (tok[NCELLS].mode == MODE_COUNT)
                    begin
                        // drop a stale count if slot_count moved during the pass
                        if (!recount_req_reg)
                        begin
                            free_count_next = cnt[NCELLS];
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        free_count_next = res_free;
                        if (out_free)
                        begin
                            load_out_res   = 1'b1;
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            load_pend  = 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    load_out_pend  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Take a slot_count write and schedule a recount
        if (cfg_wr_en)
        begin
            n_next           = (cfg_wr_data > MAX_CNT) ? MAX_CNT : cfg_wr_data;
            recount_req_next = 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            recount_req_reg <= 1'b0;
            n_reg           <= RESET_N;
            free_count_reg  <= RESET_N;
            out_valid_reg   <= 1'b0;
            head_tok_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            recount_req_reg <= recount_req_next;
            n_reg           <= n_next;
            free_count_reg  <= free_count_next;
            out_valid_reg   <= out_valid_next;
            head_tok_reg    <= head_tok_next;
        end
    end

    // Hold launch payload and result registers
    always_ff @(posedge clk)
    begin
        head_idx_reg   <= head_idx_next;
        pre_status_reg <= pre_status_next;
        if (load_pend)
        begin
            pend_status_reg  <= res_status;
            pend_address_reg <= res_address;
            pend_free_reg    <= res_free;
        end
        if (load_out_res)
        begin
            status_reg     <= res_status;
            address_reg    <= res_address;
            free_slots_reg <= res_free;
        end
        else if (load_out_pend)
        begin
            status_reg     <= pend_status_reg;
            address_reg    <= pend_address_reg;
            free_slots_reg <= pend_free_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign address    = address_reg;
    assign free_slots = free_slots_reg;

endmodule

FILE: src/bsa_checker.sv
// Port-level assertions for the bitmap slot allocator, bound to the top level.
module bsa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [bsa_pkg::STATUS_W-1:0] status,
    input logic [bsa_pkg::ADDR_W-1:0]   address,
    input logic [bsa_pkg::CNT_W-1:0]    free_slots
);
    import bsa_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(address)
                                   && $stable(free_slots))
        else $error("stalled result changed");

    // Only an ok result carries an address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> address == '0)
        else $error("address set on a failed result");

    // Allocated addresses fall on slot boundaries
    a_addr_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> address[SLOT_SHIFT-1:0] == '0)
        else $error("address not slot aligned");

    // A full map reports no free slots
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> free_slots == '0)
        else $error("full status with free slots left");

    // One item at a time: stall right after an accept
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item accepted while busy");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);
